FILE: design/ssd_pkg.sv
// ----------------------------------------------------------------------------
// ssd_pkg
// Types, constants and glyph lookup shared by the seven-segment scan driver.
// ----------------------------------------------------------------------------
package ssd_pkg;

  localparam int unsigned NUM_DIGITS  = 8;
  localparam int unsigned STORE_DEPTH = 8;
  localparam int unsigned IDX_W       = $clog2(STORE_DEPTH);
  localparam int unsigned VALUE_W     = 16;
  localparam int unsigned BCD_DIGITS  = 4;
  localparam int unsigned BCD_W       = 4 * BCD_DIGITS;
  localparam int unsigned CNT_W       = $clog2(VALUE_W);

  localparam logic       MODE_SCAN   = 1'b0;
  localparam logic       MODE_UPDATE = 1'b1;

  localparam logic [7:0] GLYPH_F     = 8'h8E;
  localparam logic [7:0] GLYPH_U     = 8'hC1;
  localparam logic [7:0] GLYPH_BLANK = 8'hFF;
  localparam logic [7:0] DP_ON_MASK  = 8'h7F;
  localparam logic [7:0] SELECT_TOP  = 8'h80;

  typedef enum logic [1:0] {
    KIND_FREQ  = 2'd0,
    KIND_VOLT  = 2'd1,
    KIND_BLANK = 2'd2,
    KIND_KEEP  = 2'd3
  } ssd_kind_e;

  typedef struct packed {
    logic              mode;
    ssd_kind_e         display_kind;
    logic [VALUE_W-1:0] value;
  } ssd_in_t;

  typedef struct packed {
    logic [7:0] digit_select;
    logic [7:0] segment_pattern;
  } ssd_out_t;

  // controller to datapath
  typedef struct packed {
    logic scan;
    logic load;
    logic shift;
    logic write_conv;
    logic blank;
  } ssd_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_blocked;
  } ssd_status_t;

  function automatic logic [7:0] digit_glyph(input logic [3:0] d);
    logic [7:0] g;
    case (d)
      4'd0:    g = 8'hC0;
      4'd1:    g = 8'hF9;
      4'd2:    g = 8'hA4;
      4'd3:    g = 8'hB0;
      4'd4:    g = 8'h99;
      4'd5:    g = 8'h92;
      4'd6:    g = 8'h82;
      4'd7:    g = 8'hF8;
      4'd8:    g = 8'h80;
      4'd9:    g = 8'h90;
      default: g = GLYPH_BLANK;
    endcase
    return g;
  endfunction

endpackage

FILE: design/ssd_ctrl.sv
// ----------------------------------------------------------------------------
// ssd_ctrl
// Sequencer: accepts requests, runs the binary-to-BCD shift count, issues
// store writes and scan commands to the datapath.
// ----------------------------------------------------------------------------
module ssd_ctrl
  import ssd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_mode_i,
  input  ssd_kind_e   in_kind_i,
  output logic        in_stall_o,
  input  ssd_status_t status_i,
  output ssd_cmd_t    cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_WRITE
  } state_e;

  state_e             state_q, state_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               accept;

  assign in_stall_o = (state_q != ST_IDLE) || status_i.out_blocked;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (in_mode_i == MODE_SCAN) begin
            cmd_o.scan = 1'b1;
          end else begin
            case (in_kind_i)
              KIND_FREQ, KIND_VOLT: begin
                cmd_o.load = 1'b1;
                cnt_d      = '0;
                state_d    = ST_CONV;
              end
              KIND_BLANK: cmd_o.blank = 1'b1;
              default: ;
            endcase
          end
        end
      end
      ST_CONV: begin
        cmd_o.shift = 1'b1;
        cnt_d       = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(VALUE_W - 1)) begin
          state_d = ST_WRITE;
        end
      end
      ST_WRITE: begin
        cmd_o.write_conv = 1'b1;
        state_d          = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

FILE: design/ssd_datapath.sv
// ----------------------------------------------------------------------------
// ssd_datapath
// Segment store, shift-add-3 BCD converter, scan index and result register.
// ----------------------------------------------------------------------------
module ssd_datapath
  import ssd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  ssd_in_t     in_data_i,
  input  ssd_cmd_t    cmd_i,
  output ssd_status_t status_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output ssd_out_t    out_data_o
);

  logic [7:0]         store_q [STORE_DEPTH];
  logic [IDX_W-1:0]   idx_q;
  logic [VALUE_W-1:0] bin_q;
  logic [BCD_W-1:0]   bcd_q;
  logic               volt_q;
  logic               out_valid_q;
  ssd_out_t           out_q;
  logic [BCD_W-1:0]   bcd_adj;
  logic [7:0]         hund_glyph;

  // add 3 to every digit of 5 or more before the shift; the carry out of
  // the thousands digit is the ten-thousands place and is dropped
  always_comb begin
    for (int i = 0; i < BCD_DIGITS; i++) begin
      bcd_adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? bcd_q[4*i +: 4] + 4'd3
                                                    : bcd_q[4*i +: 4];
    end
  end

  assign hund_glyph = digit_glyph(bcd_q[11:8]);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      bin_q  <= in_data_i.value;
      bcd_q  <= '0;
      volt_q <= (in_data_i.display_kind == KIND_VOLT);
    end else if (cmd_i.shift) begin
      {bcd_q, bin_q} <= {bcd_adj[BCD_W-2:0], bin_q, 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < STORE_DEPTH; i++) begin
        store_q[i] <= GLYPH_BLANK;
      end
    end else if (cmd_i.blank) begin
      store_q[0] <= GLYPH_BLANK;
      store_q[1] <= GLYPH_BLANK;
      store_q[2] <= GLYPH_BLANK;
      store_q[3] <= GLYPH_BLANK;
      store_q[7] <= GLYPH_BLANK;
    end else if (cmd_i.write_conv) begin
      store_q[0] <= digit_glyph(bcd_q[3:0]);
      store_q[1] <= digit_glyph(bcd_q[7:4]);
      if (volt_q) begin
        store_q[2] <= hund_glyph & DP_ON_MASK;
        store_q[3] <= GLYPH_BLANK;
        store_q[7] <= GLYPH_U;
      end else begin
        store_q[2] <= hund_glyph;
        store_q[3] <= digit_glyph(bcd_q[15:12]);
        store_q[7] <= GLYPH_F;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (cmd_i.scan) begin
      idx_q       <= (idx_q == IDX_W'(NUM_DIGITS - 1)) ? '0 : idx_q + 1'b1;
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan) begin
      out_q.digit_select    <= SELECT_TOP >> idx_q;
      out_q.segment_pattern <= store_q[idx_q];
    end
  end

  assign status_o.out_blocked = out_valid_q && out_stall_i;
  assign out_valid_o          = out_valid_q;
  assign out_data_o           = out_q;

endmodule

FILE: design/seven_segment_scan_display.sv
// ----------------------------------------------------------------------------
// seven_segment_scan_display
// Eight-digit multiplexed common-anode seven-segment display driver.
// ----------------------------------------------------------------------------
// A request on the input channel is either a scan tick (mode 0) or an update
// (mode 1). A scan tick returns one result: the one-hot digit select and the
// active-low segment byte of the current digit, then the scan index moves on
// and wraps after NUM_DIGITS digits. An update returns nothing.
// A scan result appears in the output register in the cycle after the
// request is taken. A scan tick or a blank/no-change update leaves the
// sequencer idle. A frequency or voltage update runs a load, then the
// shift-add-3 binary-to-BCD converter (one value bit a cycle), then a store
// write; input stall stays high meanwhile.
// Reset clears the scan index to 0 and every store entry to blank (0xFF).
// When the receiver stalls, the result holds in the output register and the
// input channel stalls until it is taken; with the register empty or being
// taken outside an update, a new scan request is accepted in the same cycle.
// ----------------------------------------------------------------------------
module seven_segment_scan_display
  import ssd_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  ssd_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output ssd_out_t out_data_o
);

  ssd_cmd_t    cmd;
  ssd_status_t status;

  ssd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_mode_i  (in_data_i.mode),
    .in_kind_i  (in_data_i.display_kind),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ssd_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

FILE: tb/tb_seven_segment_scan_display.sv
// ----------------------------------------------------------------------------
// tb_seven_segment_scan_display
// Self-checking bench for the eight-digit seven-segment scan driver. Scan
// ticks and display updates are fed through the request channel. A scoreboard
// keeps its own copy of the segment store and the scan position, and works out
// the select and segment byte that each scan tick must return. Random idling
// on both channels and one long output hold-off exercise the backpressure.
// ----------------------------------------------------------------------------
module tb_seven_segment_scan_display;
  import ssd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  class ssd_scoreboard;
    logic [7:0] seg_store [STORE_DEPTH];
    logic [IDX_W-1:0] scan_pos;
    ssd_out_t scan_q [$];
    int errors;

    function new();
      for (int i = 0; i < STORE_DEPTH; i++) seg_store[i] = GLYPH_BLANK;
      scan_pos = '0;
      errors = 0;
    endfunction

    function logic [7:0] decimal_glyph(int unsigned v, int unsigned div);
      logic [7:0] g;
      case ((v / div) % 10)
        0: g = 8'hC0;
        1: g = 8'hF9;
        2: g = 8'hA4;
        3: g = 8'hB0;
        4: g = 8'h99;
        5: g = 8'h92;
        6: g = 8'h82;
        7: g = 8'hF8;
        8: g = 8'h80;
        default: g = 8'h90;
      endcase
      return g;
    endfunction

    // called for every accepted request, in acceptance order
    function void note_request(ssd_in_t req);
      ssd_out_t exp;
      int unsigned v;
      v = 32'(req.value);
      if (req.mode == MODE_UPDATE) begin
        case (req.display_kind)
          KIND_FREQ: begin
            seg_store[0] = decimal_glyph(v, 1);
            seg_store[1] = decimal_glyph(v, 10);
            seg_store[2] = decimal_glyph(v, 100);
            seg_store[3] = decimal_glyph(v, 1000);
            seg_store[7] = GLYPH_F;
          end
          KIND_VOLT: begin
            seg_store[0] = decimal_glyph(v, 1);
            seg_store[1] = decimal_glyph(v, 10);
            seg_store[2] = decimal_glyph(v, 100) & DP_ON_MASK;
            seg_store[3] = GLYPH_BLANK;
            seg_store[7] = GLYPH_U;
          end
          KIND_BLANK: begin
            for (int i = 0; i < 4; i++) seg_store[i] = GLYPH_BLANK;
            seg_store[7] = GLYPH_BLANK;
          end
          default: ;
        endcase
      end else begin
        exp.digit_select    = SELECT_TOP >> scan_pos;
        exp.segment_pattern = seg_store[scan_pos];
        scan_q.push_back(exp);
        if (scan_pos + 1 >= NUM_DIGITS) scan_pos = '0;
        else scan_pos = scan_pos + 1'b1;
      end
    endfunction

    function void check_result(ssd_out_t got);
      ssd_out_t exp;
      if (scan_q.size() == 0) begin
        $display("%0t: unexpected result sel=%h seg=%h", $time,
                 got.digit_select, got.segment_pattern);
        errors++;
        return;
      end
      exp = scan_q.pop_front();
      if (got.digit_select !== exp.digit_select) begin
        $display("%0t: digit_select expected %h actual %h", $time,
                 exp.digit_select, got.digit_select);
        errors++;
      end
      if (got.segment_pattern !== exp.segment_pattern) begin
        $display("%0t: segment_pattern expected %h actual %h", $time,
                 exp.segment_pattern, got.segment_pattern);
        errors++;
      end
    endfunction

    function int pending();
      return scan_q.size();
    endfunction
  endclass

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  logic     in_stall_o;
  ssd_in_t  in_data_i   = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  ssd_out_t out_data_o;

  ssd_scoreboard sb;
  int send_gap_pct = 0;
  int stall_pct    = 0;
  int hold_left    = 0;

  seven_segment_scan_display DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always #4 clk_i = ~clk_i;

  // receiver: random stalls, plus a long hold-off when requested
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_data_o);
  end

  function automatic ssd_in_t make_req(logic mode, ssd_kind_e kind, logic [15:0] v);
    ssd_in_t r;
    r.mode = mode;
    r.display_kind = kind;
    r.value = v;
    return r;
  endfunction

  function automatic ssd_in_t rand_request();
    ssd_in_t r;
    r.mode = ($urandom_range(99) < 30) ? MODE_UPDATE : MODE_SCAN;
    r.display_kind = ssd_kind_e'($urandom_range(3));
    case ($urandom_range(7))
      0: r.value = 16'h0000;
      1: r.value = 16'hFFFF;
      2: r.value = 16'($urandom_range(9999));
      3: r.value = 16'($urandom_range(999));
      default: r.value = 16'($urandom);
    endcase
    return r;
  endfunction

  // starts and ends at a falling edge; valid stays up for back-to-back requests
  task automatic send_item(ssd_in_t req);
    while (send_gap_pct > 0 && $urandom_range(99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_request(req);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    int waited;
    waited = 0;
    in_valid_i <= 1'b0;
    while (sb.pending() != 0 && waited < 20000) begin
      @(posedge clk_i);
      waited++;
    end
    @(negedge clk_i);
  endtask

  task automatic send_scans(int n);
    for (int i = 0; i < n; i++)
      send_item(make_req(MODE_SCAN, ssd_kind_e'($urandom_range(3)), 16'($urandom)));
  endtask

  initial begin
    int gap_tab [4];
    int stall_tab [4];
    gap_tab   = '{0, 64, 0, 26};
    stall_tab = '{0, 0, 64, 26};
    sb = new();
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // blank store after reset, then the frequency kind with the top value
    send_scans(4);
    send_item(make_req(MODE_UPDATE, KIND_FREQ, 16'hFFFF));
    send_scans(8);
    // voltage with a zero hundreds digit, then a no-change update
    send_item(make_req(MODE_UPDATE, KIND_VOLT, 16'd0));
    send_item(make_req(MODE_UPDATE, KIND_KEEP, 16'd4321));
    send_scans(8);
    send_item(make_req(MODE_UPDATE, KIND_BLANK, 16'hA5A5));
    send_scans(2);
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      send_gap_pct = gap_tab[ph];
      stall_pct    = stall_tab[ph];
      // long output hold-off while requests keep coming
      if (ph == 0) hold_left = 150;
      repeat (345) send_item(rand_request());
      wait_drained();
    end

    repeat (40) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      if (sb.pending() != 0) $display("%0d scan results never arrived", sb.pending());
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #(5_000_000);
    $display("TB_ERROR");
    $finish;
  end

endmodule
